FILE: hw/rtl/bqlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad lowpass package
// Shared widths, fixed-point formats, register map, payload and control types.
// ----------------------------------------------------------------------------
package bqlp_pkg;

    // Fixed-point formats.
    localparam int SAMPLE_WIDTH   = 20;
    localparam int SAMPLE_FRAC    = SAMPLE_WIDTH - 4;
    localparam int COEF_FRAC_BITS = 30;
    localparam int STATE_FRAC     = 24;
    localparam int FF_SHIFT       = COEF_FRAC_BITS + SAMPLE_FRAC - STATE_FRAC;
    localparam int GAIN_FRAC      = 15;
    localparam int OUT_FRAC       = STATE_FRAC + GAIN_FRAC;

    localparam int COEF_WIDTH = 32;
    localparam int GAIN_WIDTH = 16;
    localparam int PCM_WIDTH  = 16;
    localparam int Y_WIDTH    = 32;
    localparam int HIST_WIDTH = 48;
    localparam int MUL_WIDTH  = 32;
    localparam int PROD_WIDTH = 2 * MUL_WIDTH;
    localparam int ACC_WIDTH  = PROD_WIDTH;

    // Configuration port.
    localparam int APB_ADDR_WIDTH = 5;
    localparam int APB_DATA_WIDTH = 32;
    localparam int REG_IDX_WIDTH  = APB_ADDR_WIDTH - 2;

    typedef enum logic [REG_IDX_WIDTH-1:0] {
        REG_COEF_B0     = 3'd0,
        REG_COEF_B1     = 3'd1,
        REG_COEF_B2     = 3'd2,
        REG_COEF_A1     = 3'd3,
        REG_COEF_A2     = 3'd4,
        REG_OUTPUT_GAIN = 3'd5
    } reg_idx_t;

    localparam logic signed [COEF_WIDTH-1:0] RST_COEF_B0 = 32'sd1303523;
    localparam logic signed [COEF_WIDTH-1:0] RST_COEF_B1 = 32'sd2607045;
    localparam logic signed [COEF_WIDTH-1:0] RST_COEF_B2 = 32'sd1303523;
    localparam logic signed [COEF_WIDTH-1:0] RST_COEF_A1 = -32'sd2050806082;
    localparam logic signed [COEF_WIDTH-1:0] RST_COEF_A2 = 32'sd982278348;
    localparam logic [GAIN_WIDTH-1:0]        RST_GAIN    = 16'd11469;

    // Payloads.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] mix_sample;
        logic                           chunk_last;
    } sample_t;

    typedef struct packed {
        logic signed [PCM_WIDTH-1:0] pcm_out;
        logic                        chunk_end;
    } pcm_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] b0;
        logic signed [COEF_WIDTH-1:0] b1;
        logic signed [COEF_WIDTH-1:0] b2;
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
        logic [GAIN_WIDTH-1:0]        gain;
    } coef_set_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_B0,
        ST_MUL_B1,
        ST_MUL_A1,
        ST_MUL_B2,
        ST_MUL_A2,
        ST_MUL_GAIN,
        ST_OUTPUT
    } state_t;

    // Multiplier operand selection.
    typedef enum logic [2:0] {
        MUL_B0_X,
        MUL_B1_X,
        MUL_A1_Y,
        MUL_B2_X,
        MUL_A2_Y,
        MUL_Y_GAIN
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        logic     y_load;
        logic     acc1_init;
        logic     acc1_fb;
        logic     acc2_init;
        logic     acc2_fb;
        logic     hist1_load;
        logic     hist2_load;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

FILE: hw/rtl/bqlp_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad lowpass register bank
// APB-style coefficient and gain registers with read-back.
// ----------------------------------------------------------------------------
module bqlp_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bqlp_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [bqlp_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [bqlp_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready,
    output bqlp_pkg::coef_set_t                  coefs
);
    import bqlp_pkg::*;

    coef_set_t coef_reg;
    coef_set_t coef_next;
    reg_idx_t  reg_idx;
    logic      wr_en;

    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_WIDTH-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign coefs   = coef_reg;

    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_COEF_B0:     coef_next.b0   = pwdata;
                REG_COEF_B1:     coef_next.b1   = pwdata;
                REG_COEF_B2:     coef_next.b2   = pwdata;
                REG_COEF_A1:     coef_next.a1   = pwdata;
                REG_COEF_A2:     coef_next.a2   = pwdata;
                REG_OUTPUT_GAIN: coef_next.gain = pwdata[GAIN_WIDTH-1:0];
                default:         coef_next      = coef_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COEF_B0:     prdata = coef_reg.b0;
            REG_COEF_B1:     prdata = coef_reg.b1;
            REG_COEF_B2:     prdata = coef_reg.b2;
            REG_COEF_A1:     prdata = coef_reg.a1;
            REG_COEF_A2:     prdata = coef_reg.a2;
            REG_OUTPUT_GAIN: prdata = APB_DATA_WIDTH'(coef_reg.gain);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0   <= RST_COEF_B0;
            coef_reg.b1   <= RST_COEF_B1;
            coef_reg.b2   <= RST_COEF_B2;
            coef_reg.a1   <= RST_COEF_A1;
            coef_reg.a2   <= RST_COEF_A2;
            coef_reg.gain <= RST_GAIN;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

endmodule

FILE: hw/rtl/bqlp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad lowpass controller
// Sequences the shared multiplier and accumulators through one sample.
// ----------------------------------------------------------------------------
module bqlp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  bqlp_pkg::dp_status_t status,
    output bqlp_pkg::dp_cmd_t    cmd
);
    import bqlp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (sample_valid) state_next = ST_MUL_B0;
            ST_MUL_B0:   state_next = ST_MUL_B1;
            ST_MUL_B1:   state_next = ST_MUL_A1;
            ST_MUL_A1:   state_next = ST_MUL_B2;
            ST_MUL_B2:   state_next = ST_MUL_A2;
            ST_MUL_A2:   state_next = ST_MUL_GAIN;
            ST_MUL_GAIN: state_next = ST_OUTPUT;
            ST_OUTPUT:   if (!status.out_busy) state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = MUL_B0_X;
        sample_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                cmd.load_in  = sample_valid;
            end
            ST_MUL_B0:
            begin
                cmd.mul_sel = MUL_B0_X;
            end
            ST_MUL_B1:
            begin
                cmd.mul_sel = MUL_B1_X;
                cmd.y_load  = 1'b1;
            end
            ST_MUL_A1:
            begin
                cmd.mul_sel   = MUL_A1_Y;
                cmd.acc1_init = 1'b1;
            end
            ST_MUL_B2:
            begin
                cmd.mul_sel = MUL_B2_X;
                cmd.acc1_fb = 1'b1;
            end
            ST_MUL_A2:
            begin
                cmd.mul_sel   = MUL_A2_Y;
                cmd.acc2_init = 1'b1;
            end
            ST_MUL_GAIN:
            begin
                cmd.mul_sel    = MUL_Y_GAIN;
                cmd.acc2_fb    = 1'b1;
                cmd.hist1_load = 1'b1;
            end
            ST_OUTPUT:
            begin
                // Keep the gain product in the multiplier register while the
                // output register is still busy.
                cmd.mul_sel    = MUL_Y_GAIN;
                cmd.hist2_load = 1'b1;
                cmd.out_load   = !status.out_busy;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/bqlp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad lowpass datapath
// Shared 32x32 multiplier, filter accumulators, history and output register.
// ----------------------------------------------------------------------------
module bqlp_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bqlp_pkg::dp_cmd_t    cmd,
    output bqlp_pkg::dp_status_t status,
    input  bqlp_pkg::coef_set_t  coefs,
    input  bqlp_pkg::sample_t    sample_data,
    output logic                 pcm_valid,
    input  logic                 pcm_ready,
    output bqlp_pkg::pcm_t       pcm_data
);
    import bqlp_pkg::*;

    localparam int CLIP_WIDTH  = OUT_FRAC + 2;
    localparam int SCALE_WIDTH = OUT_FRAC + GAIN_FRAC + 2;

    localparam logic signed [ACC_WIDTH-1:0] Y_MAX = (ACC_WIDTH'(1) <<< (Y_WIDTH - 1)) - 1;
    localparam logic signed [ACC_WIDTH-1:0] Y_MIN = -Y_MAX - 1;
    localparam logic signed [ACC_WIDTH-1:0] H_MAX = (ACC_WIDTH'(1) <<< (HIST_WIDTH - 1)) - 1;
    localparam logic signed [ACC_WIDTH-1:0] H_MIN = -H_MAX - 1;
    localparam logic signed [PROD_WIDTH-1:0] V_ONE = PROD_WIDTH'(1) <<< OUT_FRAC;
    localparam logic signed [SCALE_WIDTH-1:0] TRUNC_BIAS = (SCALE_WIDTH'(1) <<< OUT_FRAC) - 1;

    logic signed [SAMPLE_WIDTH-1:0] x_reg,     x_next;
    logic                           last_reg,  last_next;
    logic signed [PROD_WIDTH-1:0]   prod_reg,  prod_next;
    logic signed [Y_WIDTH-1:0]      y_reg,     y_next;
    logic signed [ACC_WIDTH-1:0]    acc1_reg,  acc1_next;
    logic signed [ACC_WIDTH-1:0]    acc2_reg,  acc2_next;
    logic signed [HIST_WIDTH-1:0]   hist1_reg, hist1_next;
    logic signed [HIST_WIDTH-1:0]   hist2_reg, hist2_next;
    pcm_t                           pcm_reg,   pcm_next;
    logic                           valid_reg, valid_next;

    logic signed [MUL_WIDTH-1:0]    op_a;
    logic signed [MUL_WIDTH-1:0]    op_b;
    logic signed [MUL_WIDTH-1:0]    x_ext;
    logic signed [ACC_WIDTH-1:0]    ff_term;
    logic signed [ACC_WIDTH-1:0]    fb_term;
    logic signed [ACC_WIDTH-1:0]    y_sum;
    logic signed [PROD_WIDTH-1:0]   v_clip;
    logic signed [SCALE_WIDTH-1:0]  v_ext;
    logic signed [SCALE_WIDTH-1:0]  scaled;
    logic signed [SCALE_WIDTH-1:0]  biased;
    logic signed [SCALE_WIDTH-1:0]  pcm_full;

    function automatic logic signed [Y_WIDTH-1:0] sat_y(input logic signed [ACC_WIDTH-1:0] a);
        if (a > Y_MAX)
            return Y_MAX[Y_WIDTH-1:0];
        else if (a < Y_MIN)
            return Y_MIN[Y_WIDTH-1:0];
        else
            return a[Y_WIDTH-1:0];
    endfunction

    function automatic logic signed [HIST_WIDTH-1:0] sat_h(input logic signed [ACC_WIDTH-1:0] a);
        if (a > H_MAX)
            return H_MAX[HIST_WIDTH-1:0];
        else if (a < H_MIN)
            return H_MIN[HIST_WIDTH-1:0];
        else
            return a[HIST_WIDTH-1:0];
    endfunction

    assign x_ext   = MUL_WIDTH'(x_reg);
    assign ff_term = prod_reg >>> FF_SHIFT;
    assign fb_term = prod_reg >>> COEF_FRAC_BITS;
    assign y_sum   = ff_term + ACC_WIDTH'(hist1_reg);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_B0_X:
            begin
                op_a = coefs.b0;
                op_b = x_ext;
            end
            MUL_B1_X:
            begin
                op_a = coefs.b1;
                op_b = x_ext;
            end
            MUL_A1_Y:
            begin
                op_a = coefs.a1;
                op_b = y_reg;
            end
            MUL_B2_X:
            begin
                op_a = coefs.b2;
                op_b = x_ext;
            end
            MUL_A2_Y:
            begin
                op_a = coefs.a2;
                op_b = y_reg;
            end
            MUL_Y_GAIN:
            begin
                op_a = y_reg;
                op_b = $signed(MUL_WIDTH'(coefs.gain));
            end
            default:
            begin
                op_a = coefs.b0;
                op_b = x_ext;
            end
        endcase
    end

    // Output conversion: clip to plus or minus one, scale by 32767 as a
    // shift and subtract, then divide by 2^OUT_FRAC rounding toward zero.
    always_comb
    begin
        if (prod_reg > V_ONE)
            v_clip = V_ONE;
        else if (prod_reg < -V_ONE)
            v_clip = -V_ONE;
        else
            v_clip = prod_reg;
        v_ext    = SCALE_WIDTH'($signed(v_clip[CLIP_WIDTH-1:0]));
        scaled   = (v_ext <<< GAIN_FRAC) - v_ext;
        biased   = scaled[SCALE_WIDTH-1] ? scaled + TRUNC_BIAS : scaled;
        pcm_full = biased >>> OUT_FRAC;
    end

    always_comb
    begin
        x_next     = cmd.load_in ? sample_data.mix_sample : x_reg;
        last_next  = cmd.load_in ? sample_data.chunk_last : last_reg;
        prod_next  = op_a * op_b;
        y_next     = cmd.y_load ? sat_y(y_sum) : y_reg;
        acc1_next  = acc1_reg;
        acc2_next  = acc2_reg;
        if (cmd.acc1_init)
            acc1_next = ff_term + ACC_WIDTH'(hist2_reg);
        else if (cmd.acc1_fb)
            acc1_next = acc1_reg - fb_term;
        if (cmd.acc2_init)
            acc2_next = ff_term;
        else if (cmd.acc2_fb)
            acc2_next = acc2_reg - fb_term;
        hist1_next = cmd.hist1_load ? sat_h(acc1_reg) : hist1_reg;
        hist2_next = cmd.hist2_load ? sat_h(acc2_reg) : hist2_reg;
        pcm_next   = pcm_reg;
        valid_next = valid_reg && !pcm_ready;
        if (cmd.out_load)
        begin
            pcm_next.pcm_out   = pcm_full[PCM_WIDTH-1:0];
            pcm_next.chunk_end = last_reg;
            valid_next         = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        last_reg <= last_next;
        prod_reg <= prod_next;
        y_reg    <= y_next;
        acc1_reg <= acc1_next;
        acc2_reg <= acc2_next;
        pcm_reg  <= pcm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist1_reg <= '0;
            hist2_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            hist1_reg <= hist1_next;
            hist2_reg <= hist2_next;
            valid_reg <= valid_next;
        end
    end

    assign status.out_busy = valid_reg && !pcm_ready;
    assign pcm_valid       = valid_reg;
    assign pcm_data        = pcm_reg;

endmodule

FILE: hw/rtl/biquad_lowpass_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad lowpass filter
// Second-order IIR section in transposed direct form II with PCM conversion.
// ----------------------------------------------------------------------------
// Each sample transaction carries one signed Q4.16 mixed sample and a chunk
// mark. The block runs it through the biquad, scales the result by the
// output gain, clips it to plus or minus one and emits a 16-bit PCM sample
// on the pcm channel together with the chunk mark, one result per sample.
// The five Q2.30 coefficients and the Q1.15 gain sit in an APB-style
// register bank at byte addresses 0x00 to 0x14. The user must write them only
// while the filter is idle; the block itself does not enforce this. They read
// back as stored, the gain zero-extended. All arithmetic goes through one
// shared 32x32 multiplier, used six times per sample, so a new sample is
// accepted only once the controller has gone through the six multiply steps
// and the output step and is back in idle.
// The output register lets the next sample be accepted while a PCM result
// still waits; if the receiver holds pcm_ready low, the controller waits at
// the final step until the output register frees up, and sample_ready stays
// low meanwhile.
// Reset clears the filter history, restores the default lowpass
// coefficients and gain, and empties the output register.
// ----------------------------------------------------------------------------
module biquad_lowpass_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bqlp_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [bqlp_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [bqlp_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  bqlp_pkg::sample_t                    sample_data,
    output logic                                 pcm_valid,
    input  logic                                 pcm_ready,
    output bqlp_pkg::pcm_t                       pcm_data
);
    import bqlp_pkg::*;

    coef_set_t  coefs;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Coefficient and gain registers; they feed the datapath directly.
    bqlp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    // The controller steps through the multiplies of one sample and owns
    // the input handshake.
    bqlp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // The datapath holds the sample, the shared multiplier, the filter
    // history and the output register with its valid flag.
    bqlp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .coefs       (coefs),
        .sample_data (sample_data),
        .pcm_valid   (pcm_valid),
        .pcm_ready   (pcm_ready),
        .pcm_data    (pcm_data)
    );

endmodule

FILE: hw/rtl/bqlp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad lowpass port checker
// Checks sequencing and output range as seen on the top-level ports.
// ----------------------------------------------------------------------------
module bqlp_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 sample_valid,
    input logic                                 sample_ready,
    input logic                                 pcm_valid,
    input logic                                 pcm_ready,
    input bqlp_pkg::pcm_t                       pcm_data
);
    import bqlp_pkg::*;

    // After a sample transaction the filter is busy and sample_ready stays low.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready ##1 !sample_ready)
    else $error("sample accepted while the previous one is still in the filter");

    // A result never appears right after the sample that caused it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pcm_valid) |-> !$past(sample_valid && sample_ready))
    else $error("pcm result appeared one cycle after sample acceptance");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        pcm_valid && !pcm_ready |=> pcm_valid && $stable(pcm_data))
    else $error("pcm result changed while stalled");

    // Clipping keeps the output symmetric, so the most negative code never shows.
    assert property (@(posedge clk) disable iff (!rst_n)
        pcm_valid |-> pcm_data.pcm_out != 16'sh8000)
    else $error("pcm output outside the clipped range");

endmodule

bind biquad_lowpass_filter bqlp_checker u_checker (.*);
